// File: sv/rbmc_pkg.sv
// Package for the RGBA blend-mode compositor: payload types, codes and constants.
`timescale 1ns / 1ps

package rbmc_pkg;

    localparam int unsigned STAGES    = 5;
    localparam int unsigned CHANNELS  = 3;

    localparam logic [2:0] MODE_NORMAL   = 3'd0;
    localparam logic [2:0] MODE_MULTIPLY = 3'd1;
    localparam logic [2:0] MODE_SCREEN   = 3'd2;
    localparam logic [2:0] MODE_OVERLAY  = 3'd3;
    localparam logic [2:0] MODE_ADDITIVE = 3'd4;

    localparam logic REG_BLEND_MODE = 1'b0;
    localparam logic REG_OPACITY    = 1'b1;

    localparam logic [7:0]  CHAN_MAX      = 8'd255;
    localparam logic [7:0]  OVERLAY_SPLIT = 8'd128;
    localparam logic [8:0]  FULL_OPACITY  = 9'd256;
    localparam logic [15:0] MIX_DIV       = 16'd65280;

    // x / 255 == (x * DIV255_MUL) >> DIV255_SHIFT for x below 2**17
    localparam logic [34:0] DIV255_MUL   = 35'd131587;
    localparam int unsigned DIV255_SHIFT = 25;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_DIV,
        KIND_INV_DIV
    } blend_kind_t;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] base_alpha;
        logic [7:0] over_red;
        logic [7:0] over_green;
        logic [7:0] over_blue;
        logic [7:0] over_alpha;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } pix_out_t;

    typedef struct packed {
        blend_kind_t kind;
        logic [16:0] prod;
        logic [7:0]  base;
    } chan_s1_t;

    typedef struct packed {
        blend_kind_t kind;
        logic [34:0] quot_prod;
        logic [7:0]  direct;
        logic [7:0]  base;
    } chan_s2_t;

    typedef struct packed {
        logic [23:0] mix_over;
        logic [23:0] mix_base;
    } chan_s3_t;

endpackage

// File: sv/rgba_blend_mode_compositor_top.sv
// Top level of the RGBA blend-mode compositor: five-stage blend and alpha-mix pipeline.
// Throughput: one beat per cycle while the output is not stalled; the stage chain of
// blend multiply, divide-by-255 multiply, mix multiplies and a final divide-by-255
// multiply sets the depth.
// A stalled output holds the pipeline; empty stages still fill behind it.
// Reset (asynchronous, active low) empties all stages, sets blend_mode to normal
// and opacity_q8 to 256.
`timescale 1ns / 1ps

module rgba_blend_mode_compositor_top
    import rbmc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_we,
    input  logic     cfg_index,
    input  logic [8:0] cfg_data,
    input  logic     in_valid,
    output logic     in_stall,
    input  pix_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output pix_out_t out_data
);

    logic [2:0] blend_mode_reg, blend_mode_next;
    logic [8:0] opacity_reg, opacity_next;

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] ready;
    logic              in_accept;

    logic [7:0]  in_base [CHANNELS];
    logic [7:0]  in_over [CHANNELS];
    logic [8:0]  add_sum [CHANNELS];
    logic [8:0]  op_sat;
    logic [16:0] alpha_full;

    chan_s1_t    s1_chan_reg [CHANNELS];
    chan_s1_t    s1_chan_next [CHANNELS];
    logic [15:0] s1_a_reg, s1_a_next;
    logic [7:0]  s1_alpha_reg, s1_alpha_next;

    chan_s2_t    s2_chan_reg [CHANNELS];
    chan_s2_t    s2_chan_next [CHANNELS];
    logic [15:0] s2_a_reg, s2_a_next;
    logic [7:0]  s2_alpha_reg, s2_alpha_next;
    logic [8:0]  alpha_sum;

    chan_s3_t    s3_chan_reg [CHANNELS];
    chan_s3_t    s3_chan_next [CHANNELS];
    logic [7:0]  s3_alpha_reg, s3_alpha_next;
    logic [7:0]  blend_val [CHANNELS];
    logic [7:0]  quot [CHANNELS];

    logic [34:0] s4_prod_reg [CHANNELS];
    logic [34:0] s4_prod_next [CHANNELS];
    logic [7:0]  s4_alpha_reg, s4_alpha_next;
    logic [23:0] mix_num [CHANNELS];

    pix_out_t    out_data_reg, out_data_next;

    always_comb
    begin
        blend_mode_next = blend_mode_reg;
        opacity_next    = opacity_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BLEND_MODE: blend_mode_next = cfg_data[2:0];
                REG_OPACITY:    opacity_next    = cfg_data;
                default:        blend_mode_next = blend_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        ready[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign in_stall  = !ready[0];
    assign in_accept = in_valid && ready[0];

    always_comb
    begin
        valid_next[0] = ready[0] ? in_accept : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    // stage 1: blend products and effective alpha
    assign in_base[0] = in_data.base_red;
    assign in_base[1] = in_data.base_green;
    assign in_base[2] = in_data.base_blue;
    assign in_over[0] = in_data.over_red;
    assign in_over[1] = in_data.over_green;
    assign in_over[2] = in_data.over_blue;

    assign op_sat        = (opacity_reg > FULL_OPACITY) ? FULL_OPACITY : opacity_reg;
    assign alpha_full    = 17'(in_data.over_alpha) * 17'(op_sat);
    assign s1_a_next     = alpha_full[15:0];
    assign s1_alpha_next = in_data.base_alpha;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            add_sum[c]           = {1'b0, in_base[c]} + {1'b0, in_over[c]};
            s1_chan_next[c].base = in_base[c];
            s1_chan_next[c].kind = KIND_DIRECT;
            s1_chan_next[c].prod = 17'(in_over[c]);
            case (blend_mode_reg)
                MODE_MULTIPLY:
                begin
                    s1_chan_next[c].kind = KIND_DIV;
                    s1_chan_next[c].prod = 17'(in_base[c]) * 17'(in_over[c]);
                end
                MODE_SCREEN:
                begin
                    s1_chan_next[c].kind = KIND_INV_DIV;
                    s1_chan_next[c].prod = 17'(CHAN_MAX - in_base[c])
                                         * 17'(CHAN_MAX - in_over[c]);
                end
                MODE_OVERLAY:
                begin
                    if (in_base[c] < OVERLAY_SPLIT)
                    begin
                        s1_chan_next[c].kind = KIND_DIV;
                        s1_chan_next[c].prod = (17'(in_base[c]) * 17'(in_over[c])) << 1;
                    end
                    else
                    begin
                        s1_chan_next[c].kind = KIND_INV_DIV;
                        s1_chan_next[c].prod = (17'(CHAN_MAX - in_base[c])
                                             * 17'(CHAN_MAX - in_over[c])) << 1;
                    end
                end
                MODE_ADDITIVE:
                begin
                    s1_chan_next[c].kind = KIND_DIRECT;
                    s1_chan_next[c].prod = add_sum[c][8] ? 17'(CHAN_MAX)
                                                         : 17'(add_sum[c][7:0]);
                end
                default:
                begin
                    s1_chan_next[c].kind = KIND_DIRECT;
                    s1_chan_next[c].prod = 17'(in_over[c]);
                end
            endcase
        end
    end

    // stage 2: divide-by-255 product and output alpha
    assign alpha_sum     = {1'b0, s1_alpha_reg} + {1'b0, s1_a_reg[15:8]};
    assign s2_alpha_next = alpha_sum[8] ? CHAN_MAX : alpha_sum[7:0];
    assign s2_a_next     = s1_a_reg;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            s2_chan_next[c].kind      = s1_chan_reg[c].kind;
            s2_chan_next[c].quot_prod = 35'(s1_chan_reg[c].prod) * DIV255_MUL;
            s2_chan_next[c].direct    = s1_chan_reg[c].prod[7:0];
            s2_chan_next[c].base      = s1_chan_reg[c].base;
        end
    end

    // stage 3: resolve blended value, form both mix terms
    assign s3_alpha_next = s2_alpha_reg;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            quot[c] = s2_chan_reg[c].quot_prod[DIV255_SHIFT +: 8];
            case (s2_chan_reg[c].kind)
                KIND_DIV:     blend_val[c] = quot[c];
                KIND_INV_DIV: blend_val[c] = CHAN_MAX - quot[c];
                default:      blend_val[c] = s2_chan_reg[c].direct;
            endcase
            s3_chan_next[c].mix_over = 24'(blend_val[c]) * 24'(s2_a_reg);
            s3_chan_next[c].mix_base = 24'(s2_chan_reg[c].base) * 24'(MIX_DIV - s2_a_reg);
        end
    end

    // stage 4: sum, drop the low byte, divide-by-255 product
    assign s4_alpha_next = s3_alpha_reg;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            mix_num[c]      = s3_chan_reg[c].mix_over + s3_chan_reg[c].mix_base;
            s4_prod_next[c] = 35'(mix_num[c][23:8]) * DIV255_MUL;
        end
    end

    // stage 5: output register
    always_comb
    begin
        out_data_next.out_red   = s4_prod_reg[0][DIV255_SHIFT +: 8];
        out_data_next.out_green = s4_prod_reg[1][DIV255_SHIFT +: 8];
        out_data_next.out_blue  = s4_prod_reg[2][DIV255_SHIFT +: 8];
        out_data_next.out_alpha = s4_alpha_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= MODE_NORMAL;
            opacity_reg    <= FULL_OPACITY;
            valid_reg      <= '0;
        end
        else
        begin
            blend_mode_reg <= blend_mode_next;
            opacity_reg    <= opacity_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            s1_chan_reg  <= s1_chan_next;
            s1_a_reg     <= s1_a_next;
            s1_alpha_reg <= s1_alpha_next;
        end
        if (ready[1])
        begin
            s2_chan_reg  <= s2_chan_next;
            s2_a_reg     <= s2_a_next;
            s2_alpha_reg <= s2_alpha_next;
        end
        if (ready[2])
        begin
            s3_chan_reg  <= s3_chan_next;
            s3_alpha_reg <= s3_alpha_next;
        end
        if (ready[3])
        begin
            s4_prod_reg  <= s4_prod_next;
            s4_alpha_reg <= s4_alpha_next;
        end
        if (ready[4])
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_data  = out_data_reg;

endmodule

// File: sv/rbmc_checker.sv
// Port-level checker for the RGBA blend-mode compositor, bound to the top level.
`timescale 1ns / 1ps

module rbmc_checker
    import rbmc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input logic     out_valid,
    input logic     out_stall,
    input pix_out_t out_data
);

    // hold a stalled output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    // free-flowing output means the input never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output flows");

    // reset empties the pipeline
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // drain: no accepted input and no output stall across the pipeline depth leave nothing behind
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(in_valid && !in_stall, 1) && !$past(out_stall, 1) &&
        !$past(in_valid && !in_stall, 2) && !$past(out_stall, 2) &&
        !$past(in_valid && !in_stall, 3) && !$past(out_stall, 3) &&
        !$past(in_valid && !in_stall, 4) && !$past(out_stall, 4) &&
        !$past(in_valid && !in_stall, 5) && !$past(out_stall, 5) &&
        $past(rst_n, 5)
        |-> !out_valid)
        else $error("output beat without a matching input beat");

endmodule

bind rgba_blend_mode_compositor_top rbmc_checker u_rbmc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// File: bench/rgba_blend_mode_compositor_checker.sv
// Checker for the RGBA blend-mode compositor: predicts each output pixel and compares it.
`timescale 1ns / 1ps

module rgba_blend_mode_compositor_checker
    import rbmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [8:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  pix_in_t    in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  pix_out_t   out_data,
    output int         fail_count,
    output int         pending
);

    logic [2:0] mode_q;
    logic [8:0] opacity_q;
    pix_out_t   expected_pixels[$];
    string      field_names[4] = '{"out_red", "out_green", "out_blue", "out_alpha"};

    function automatic logic [7:0] blend_chan(input logic [2:0] mode, input logic [7:0] b,
                                              input logic [7:0] s);
        logic [17:0] prod;
        logic [7:0]  inv_b;
        logic [7:0]  inv_s;
        logic [8:0]  sum;
        logic [7:0]  res;
        inv_b = CHAN_MAX - b;
        inv_s = CHAN_MAX - s;
        case (mode)
            MODE_MULTIPLY:
            begin
                prod = 18'(b) * 18'(s);
                res  = 8'(prod / 18'd255);
            end
            MODE_SCREEN:
            begin
                prod = 18'(inv_b) * 18'(inv_s);
                res  = CHAN_MAX - 8'(prod / 18'd255);
            end
            MODE_OVERLAY:
            begin
                if (b < OVERLAY_SPLIT)
                begin
                    prod = (18'(b) * 18'(s)) << 1;
                    res  = 8'(prod / 18'd255);
                end
                else
                begin
                    prod = (18'(inv_b) * 18'(inv_s)) << 1;
                    res  = CHAN_MAX - 8'(prod / 18'd255);
                end
            end
            MODE_ADDITIVE:
            begin
                sum = 9'(b) + 9'(s);
                res = (sum > 9'(CHAN_MAX)) ? CHAN_MAX : sum[7:0];
            end
            default:
            begin
                res = s;
            end
        endcase
        return res;
    endfunction

    function automatic logic [7:0] mix_chan(input logic [7:0] blended, input logic [7:0] b,
                                            input logic [16:0] a);
        logic [39:0] num;
        num = 40'(blended) * 40'(a) + 40'(b) * (40'(MIX_DIV) - 40'(a));
        return 8'(num / 40'(MIX_DIV));
    endfunction

    function automatic pix_out_t composite_pixel(input pix_in_t p, input logic [2:0] mode,
                                                 input logic [8:0] opacity);
        logic [8:0]  op;
        logic [16:0] a;
        logic [9:0]  alpha_sum;
        pix_out_t    r;
        op = (opacity > FULL_OPACITY) ? FULL_OPACITY : opacity;
        a  = 17'(p.over_alpha) * 17'(op);
        r.out_red   = mix_chan(blend_chan(mode, p.base_red, p.over_red), p.base_red, a);
        r.out_green = mix_chan(blend_chan(mode, p.base_green, p.over_green), p.base_green, a);
        r.out_blue  = mix_chan(blend_chan(mode, p.base_blue, p.over_blue), p.base_blue, a);
        alpha_sum   = 10'(p.base_alpha) + 10'(a[16:8]);
        r.out_alpha = (alpha_sum > 10'(CHAN_MAX)) ? CHAN_MAX : alpha_sum[7:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        int       errs;
        int       delta;
        if (!rst_n)
        begin
            mode_q     <= MODE_NORMAL;
            opacity_q  <= FULL_OPACITY;
            expected_pixels.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            errs  = 0;
            delta = 0;
            if (cfg_we)
            begin
                if (cfg_index == REG_BLEND_MODE)
                    mode_q <= cfg_data[2:0];
                else
                    opacity_q <= cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                expected_pixels.push_back(composite_pixel(in_data, mode_q, opacity_q));
                delta++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected output beat, actual %h", $time, out_data);
                    errs++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    delta--;
                    for (int k = 0; k < 4; k++)
                    begin
                        if (want[31 - 8 * k -: 8] !== out_data[31 - 8 * k -: 8])
                        begin
                            $display("%0t: %s mismatch, expected %0d actual %0d", $time,
                                     field_names[k], want[31 - 8 * k -: 8],
                                     out_data[31 - 8 * k -: 8]);
                            errs++;
                        end
                    end
                end
            end
            pending    <= pending + delta;
            fail_count <= fail_count + errs;
        end
    end

endmodule

// File: bench/rgba_blend_mode_compositor_top_tb.sv
// Testbench top for the RGBA blend-mode compositor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rgba_blend_mode_compositor_top_tb;
    import rbmc_pkg::*;

    localparam int RANDOM_ITEMS = 1350;
    localparam int LONG_HOLD    = 200;
    localparam int IDLE_LIMIT   = 4000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [8:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    pix_in_t    in_data;
    logic       out_valid;
    logic       out_stall;
    pix_out_t   out_data;
    int         fail_count;
    int         pending;

    bit tx_calm;
    bit rx_calm;
    bit hold_req;
    int stall_left;
    int idle_cycles;

    rgba_blend_mode_compositor_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    rgba_blend_mode_compositor_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_chan();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return 8'd0;
        else if (r < 24)
            return CHAN_MAX;
        else if (r < 32)
            return OVERLAY_SPLIT - 8'(r & 1);
        else
            return 8'($urandom);
    endfunction

    function automatic pix_in_t random_pixel();
        pix_in_t p;
        p.base_red   = rand_chan();
        p.base_green = rand_chan();
        p.base_blue  = rand_chan();
        p.base_alpha = rand_chan();
        p.over_red   = rand_chan();
        p.over_green = rand_chan();
        p.over_blue  = rand_chan();
        p.over_alpha = rand_chan();
        return p;
    endfunction

    function automatic pix_in_t pixel(input logic [7:0] br, input logic [7:0] bg,
                                      input logic [7:0] bb, input logic [7:0] ba,
                                      input logic [7:0] sr, input logic [7:0] sg,
                                      input logic [7:0] sb, input logic [7:0] sa);
        pix_in_t p;
        p = {br, bg, bb, ba, sr, sg, sb, sa};
        return p;
    endfunction

    task automatic send_pixel(input pix_in_t p);
        int gap;
        gap = 0;
        if (!tx_calm && $urandom_range(99) < 30)
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [2:0] mode, input logic [8:0] opacity);
        write_reg(REG_BLEND_MODE, {6'd0, mode});
        write_reg(REG_OPACITY, opacity);
    endtask

    initial
    begin
        out_stall  <= 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!rx_calm && $urandom_range(99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [2:0] dir_modes[4];
        pix_in_t    mixed_px;
        pix_in_t    bright_px;
        int         items_sent;
        int         seg;
        int         seg_len;
        int         r;
        logic [2:0] mode;
        logic [8:0] opacity;

        dir_modes   = '{MODE_MULTIPLY, MODE_SCREEN, MODE_OVERLAY, MODE_ADDITIVE};
        mixed_px    = pixel(8'd127, 8'd128, 8'd255, 8'd200, 8'd255, 8'd0, 8'd128, 8'd128);
        bright_px   = pixel(8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255);
        idle_cycles = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;
        hold_req    = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= REG_BLEND_MODE;
        cfg_data    <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pixel('0);
        send_pixel('1);
        send_pixel(pixel(8'd10, 8'd20, 8'd30, 8'd40, 8'd200, 8'd100, 8'd50, 8'd0));
        for (int m = 0; m < 4; m++)
        begin
            apply_setting(dir_modes[m], FULL_OPACITY);
            send_pixel(mixed_px);
            send_pixel(bright_px);
        end
        write_reg(REG_BLEND_MODE, {6'b101101, 3'd7});
        send_pixel(pixel(8'd50, 8'd60, 8'd70, 8'd80, 8'd200, 8'd10, 8'd90, 8'd255));
        apply_setting(MODE_OVERLAY, 9'd0);
        send_pixel(pixel(8'd200, 8'd30, 8'd128, 8'd100, 8'd17, 8'd240, 8'd99, 8'd255));
        apply_setting(MODE_SCREEN, 9'd511);
        send_pixel(pixel(8'd200, 8'd30, 8'd128, 8'd100, 8'd17, 8'd240, 8'd99, 8'd255));
        write_reg(REG_OPACITY, 9'd257);
        send_pixel(mixed_px);
        apply_setting(MODE_ADDITIVE, 9'd1);
        send_pixel(pixel(8'd3, 8'd250, 8'd128, 8'd254, 8'd252, 8'd9, 8'd127, 8'd255));

        items_sent = 0;
        seg        = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(20, 80);
            if (seg == 0 || $urandom_range(99) < 40)
            begin
                r    = $urandom_range(99);
                mode = (r < 85) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
                case ($urandom_range(0, 9))
                    0:       opacity = 9'd0;
                    1:       opacity = FULL_OPACITY;
                    2:       opacity = 9'd511;
                    3:       opacity = 9'd257;
                    4:       opacity = 9'd1;
                    5:       opacity = 9'd255;
                    6:       opacity = 9'($urandom_range(257, 511));
                    default: opacity = 9'($urandom_range(0, 256));
                endcase
                if ($urandom_range(3) == 0)
                    write_reg(REG_BLEND_MODE, {6'($urandom), mode});
                else
                    write_reg(REG_BLEND_MODE, {6'd0, mode});
                write_reg(REG_OPACITY, opacity);
            end
            tx_calm = ($urandom_range(3) == 0);
            rx_calm = ($urandom_range(3) == 0);
            if (seg == 2 || $urandom_range(99) < 4)
            begin
                tx_calm  = 1'b1;
                hold_req = 1'b1;
            end
            for (int i = 0; i < seg_len; i++)
            begin
                if ((seg == 5 || seg == 11) && i == seg_len / 2)
                    drain();
                send_pixel(random_pixel());
            end
            items_sent += seg_len;
            seg++;
        end

        drain();
        repeat (4 * STAGES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
